// ----- hw/rtl/dmarf_pkg.sv -----
// Package for the DMA register front end: word types, op/kind/status codes,
// register map, launch word order and small helper functions.
// No dependencies.
package dmarf_pkg;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_DONE  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        KIND_RESP  = 2'd0,
        KIND_REQ   = 2'd1,
        KIND_EVENT = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_DENIED  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        SEL_STATUS  = 2'd0,
        SEL_NEXT_ID = 2'd1,
        SEL_DONE_ID = 2'd2
    } t_sel;

    typedef struct packed {
        t_op         operation;
        logic [1:0]  port;
        logic [11:0] offset;
        logic [3:0]  size_bytes;
        logic [31:0] write_data;
        logic        done_stream;
        logic        clock_enabled;
        logic        queue_full;
        logic [7:0]  backend_busy_bits;
        logic        midend_busy;
    } t_in_word;

    typedef struct packed {
        t_kind       kind;
        t_status     status;
        logic [31:0] data;
        logic [3:0]  word_index;
        logic        last;
    } t_out_word;

    typedef logic [3:0] t_reg_idx;
    typedef logic [3:0] t_seq;

    typedef struct packed {
        logic     hit;
        t_reg_idx idx;
    } t_reg_hit;

    localparam int REGS_PER_PORT = 10;

    localparam t_reg_idx REG_CFG   = 4'd0;
    localparam t_reg_idx REG_DST   = 4'd1;
    localparam t_reg_idx REG_SRC   = 4'd2;
    localparam t_reg_idx REG_LEN   = 4'd3;
    localparam t_reg_idx REG_DST_2 = 4'd4;
    localparam t_reg_idx REG_SRC_2 = 4'd5;
    localparam t_reg_idx REG_REPS2 = 4'd6;
    localparam t_reg_idx REG_DST_3 = 4'd7;
    localparam t_reg_idx REG_SRC_3 = 4'd8;
    localparam t_reg_idx REG_REPS3 = 4'd9;

    localparam logic [11:0] OFS_CONF  = 12'h000;
    localparam logic [11:0] OFS_DST   = 12'h0D0;
    localparam logic [11:0] OFS_SRC   = 12'h0D8;
    localparam logic [11:0] OFS_LEN   = 12'h0E0;
    localparam logic [11:0] OFS_DST_2 = 12'h0E8;
    localparam logic [11:0] OFS_SRC_2 = 12'h0F0;
    localparam logic [11:0] OFS_REPS2 = 12'h0F8;
    localparam logic [11:0] OFS_DST_3 = 12'h100;
    localparam logic [11:0] OFS_SRC_3 = 12'h108;
    localparam logic [11:0] OFS_REPS3 = 12'h110;

    localparam logic [11:0] STREAM_BASE = 12'h004;
    localparam logic [3:0]  SIZE_WORD   = 4'd4;
    localparam logic [31:0] LOWEST_ID   = 32'd2;
    localparam logic [31:0] FIRST_DONE  = 32'd1;

    localparam t_seq SEQ_RESP = 4'd0;
    localparam t_seq SEQ_CTRL = 4'd10;
    localparam t_seq SEQ_ID   = 4'd11;

    function automatic t_reg_hit f_reg_index(input logic [11:0] ofs);
        t_reg_hit r;
        r.hit = 1'b1;
        case (ofs)
            OFS_CONF:  r.idx = REG_CFG;
            OFS_DST:   r.idx = REG_DST;
            OFS_SRC:   r.idx = REG_SRC;
            OFS_LEN:   r.idx = REG_LEN;
            OFS_DST_2: r.idx = REG_DST_2;
            OFS_SRC_2: r.idx = REG_SRC_2;
            OFS_REPS2: r.idx = REG_REPS2;
            OFS_DST_3: r.idx = REG_DST_3;
            OFS_SRC_3: r.idx = REG_SRC_3;
            OFS_REPS3: r.idx = REG_REPS3;
            default: begin
                r.hit = 1'b0;
                r.idx = REG_CFG;
            end
        endcase
        return r;
    endfunction

    // Port register feeding each launch word slot.
    function automatic t_reg_idx f_src_reg(input t_seq seq);
        t_reg_idx r;
        case (seq)
            4'd1:    r = REG_SRC;
            4'd2:    r = REG_DST;
            4'd3:    r = REG_LEN;
            4'd4:    r = REG_SRC_2;
            4'd5:    r = REG_DST_2;
            4'd6:    r = REG_REPS2;
            4'd7:    r = REG_SRC_3;
            4'd8:    r = REG_DST_3;
            4'd9:    r = REG_REPS3;
            default: r = REG_CFG;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] f_bump(input logic [31:0] v);
        logic [31:0] n;
        n = v + 32'd1;
        return (n < LOWEST_ID) ? LOWEST_ID : n;
    endfunction

endpackage

// ----- hw/rtl/dmarf_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dmarf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 40
) (
    input  logic                                  i_clk,
    input  logic                                  i_wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                      i_wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                      o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_q <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_q;

endmodule

// ----- hw/rtl/dma_register_frontend.sv -----
// Top level of the DMA register front end: bus decode, request file,
// NEXT_ID/DONE_ID counters and launch word sequencer.
// Depends on dmarf_pkg and dmarf_ram.

// Items enter a front register and leave through an output register, so a
// new word is taken while a finished result still waits downstream. An item
// with a single result (bus response or completion pulse) holds the front
// stage until the output register takes it; a NEXT_ID read that launches a
// request holds it while it emits its 12 words, one at a time, since the
// request file has one read port and each request word is fetched in its own
// cycle. Operation 3 and completions on a nonexistent stream are dropped with no result.
module dma_register_frontend
    import dmarf_pkg::*;
#(
    parameter int NUM_PORTS   = 4,
    parameter int NUM_STREAMS = 2
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    localparam int DEPTH = NUM_PORTS * REGS_PER_PORT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW    = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;
    localparam logic [9:0]  NS1     = 10'(NUM_STREAMS);
    localparam logic [9:0]  NS2     = 10'(2 * NUM_STREAMS);
    localparam logic [11:0] BLK_END = 12'(4 + 12 * NUM_STREAMS);

    logic             r_a_valid;
    t_in_word         r_a;
    t_seq             r_seq;
    logic [31:0]      r_id;
    logic [31:0]      r_next_id [NUM_STREAMS];
    logic [31:0]      r_done_id [NUM_STREAMS];
    logic [DEPTH-1:0] r_vld;
    logic             r_rd_vld;
    logic             r_fwd_hit;
    logic [31:0]      r_fwd_data;
    logic             r_out_valid;
    t_out_word        r_out;

    t_reg_hit    w_reg;
    t_reg_hit    w_in_reg;
    logic        w_bad;
    logic        w_in_blk;
    logic [9:0]  w_widx;
    t_sel        w_sel;
    logic [9:0]  w_sbase;
    logic [SW-1:0] w_s;
    logic [SW-1:0] w_cnt_s;
    logic        w_done_ok;
    logic        w_launch;
    logic [31:0] w_ram_q;
    logic [31:0] w_rd_data;
    logic [31:0] w_next_cur;
    logic [31:0] w_ctrl;
    t_out_word   w_res;
    logic        w_has;
    logic        w_wr_en;
    logic        w_next_upd;
    logic        w_done_upd;
    logic        w_out_free;
    logic        w_a_emit;
    logic        w_a_done;
    logic        w_in_acc;
    logic [1:0]  w_rd_port;
    t_seq        w_rd_seq;
    t_reg_idx    w_rd_dec;
    t_reg_idx    w_rd_reg;
    logic [AW-1:0] w_rd_addr;
    logic [AW-1:0] w_wr_addr;

    // Decode of the held item
    assign w_reg    = f_reg_index(r_a.offset);
    assign w_in_reg = f_reg_index(i_in_word.offset);
    assign w_bad    = !r_a.clock_enabled || (r_a.size_bytes != SIZE_WORD) ||
                      (int'(r_a.port) >= NUM_PORTS);
    assign w_in_blk = (r_a.offset >= STREAM_BASE) && (r_a.offset < BLK_END);
    assign w_widx   = 10'((r_a.offset - STREAM_BASE) >> 2);

    always_comb begin
        if (w_widx >= NS2) begin
            w_sel   = SEL_DONE_ID;
            w_sbase = NS2;
        end else if (w_widx >= NS1) begin
            w_sel   = SEL_NEXT_ID;
            w_sbase = NS1;
        end else begin
            w_sel   = SEL_STATUS;
            w_sbase = 10'd0;
        end
    end

    assign w_s       = SW'(w_widx - w_sbase);
    assign w_cnt_s   = (r_a.operation == OP_DONE) ? SW'(r_a.done_stream) : w_s;
    assign w_done_ok = int'(r_a.done_stream) < NUM_STREAMS;
    assign w_launch  = (r_a.operation == OP_READ) && !w_bad && w_in_blk &&
                       (w_sel == SEL_NEXT_ID) && !r_a.queue_full;
    assign w_rd_data = r_fwd_hit ? r_fwd_data : (r_rd_vld ? w_ram_q : 32'd0);
    assign w_next_cur = r_next_id[w_cnt_s];
    assign w_ctrl    = {18'd0, 4'(w_s), w_rd_data[1], w_rd_data[0],
                        w_rd_data[17:15], w_rd_data[14:12], w_rd_data[11:10]};

    always_comb begin
        w_has          = 1'b1;
        w_wr_en        = 1'b0;
        w_next_upd     = 1'b0;
        w_done_upd     = 1'b0;
        w_res.kind       = KIND_RESP;
        w_res.status     = ST_OK;
        w_res.data       = 32'd0;
        w_res.word_index = 4'd0;
        w_res.last       = 1'b1;
        case (r_a.operation)
            OP_DONE: begin
                if (w_done_ok) begin
                    w_res.kind = KIND_EVENT;
                    w_res.data = f_bump(r_done_id[w_cnt_s]);
                    w_done_upd = 1'b1;
                end else begin
                    w_has = 1'b0;
                end
            end
            OP_READ, OP_WRITE: begin
                if (w_bad) begin
                    w_res.status = ST_INVALID;
                end else if (w_launch) begin
                    case (r_seq)
                        SEQ_RESP: begin
                            w_res.data = w_next_cur;
                            w_res.last = 1'b0;
                            w_next_upd = 1'b1;
                        end
                        SEQ_CTRL: begin
                            w_res.kind       = KIND_REQ;
                            w_res.data       = w_ctrl;
                            w_res.word_index = 4'd9;
                            w_res.last       = 1'b0;
                        end
                        SEQ_ID: begin
                            w_res.kind       = KIND_REQ;
                            w_res.data       = r_id;
                            w_res.word_index = 4'd10;
                        end
                        default: begin
                            w_res.kind       = KIND_REQ;
                            w_res.data       = w_rd_data;
                            w_res.word_index = r_seq - 4'd1;
                            w_res.last       = 1'b0;
                        end
                    endcase
                end else if (w_in_blk) begin
                    if (r_a.operation == OP_READ) begin
                        case (w_sel)
                            SEL_NEXT_ID: w_res.status = ST_DENIED;
                            SEL_STATUS:  w_res.data = {23'd0, r_a.midend_busy,
                                                       r_a.backend_busy_bits};
                            SEL_DONE_ID: w_res.data = r_done_id[w_cnt_s];
                            default:     w_res.data = 32'd0;
                        endcase
                    end
                end else if (w_reg.hit) begin
                    if (r_a.operation == OP_WRITE) begin
                        w_wr_en = 1'b1;
                    end else begin
                        w_res.data = w_rd_data;
                    end
                end else begin
                    w_res.status = ST_INVALID;
                end
            end
            default: w_has = 1'b0;
        endcase
    end

    // Handshake
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_a_emit   = r_a_valid && w_has && w_out_free;
    assign w_a_done   = r_a_valid && (!w_has || (w_out_free && w_res.last));
    assign o_in_stall = r_a_valid && !w_a_done;
    assign w_in_acc   = i_in_valid && !o_in_stall;

    // Request file read address for the word held next cycle
    always_comb begin
        if (w_in_acc) begin
            w_rd_port = i_in_word.port;
            w_rd_seq  = SEQ_RESP;
            w_rd_dec  = w_in_reg.idx;
        end else if (w_a_emit && !w_res.last) begin
            w_rd_port = r_a.port;
            w_rd_seq  = r_seq + 4'd1;
            w_rd_dec  = w_reg.idx;
        end else begin
            w_rd_port = r_a.port;
            w_rd_seq  = r_seq;
            w_rd_dec  = w_reg.idx;
        end
        w_rd_reg = (w_rd_seq == SEQ_RESP) ? w_rd_dec : f_src_reg(w_rd_seq);
    end

    assign w_rd_addr = AW'(int'(w_rd_port) * REGS_PER_PORT + int'(w_rd_reg));
    assign w_wr_addr = AW'(int'(r_a.port) * REGS_PER_PORT + int'(w_reg.idx));

    dmarf_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_req_file (
        .i_clk     (i_clk),
        .i_wr_en   (w_a_emit && w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (r_a.write_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_seq       <= SEQ_RESP;
            r_out_valid <= 1'b0;
            r_vld       <= '0;
            r_rd_vld    <= 1'b0;
            r_fwd_hit   <= 1'b0;
            for (int i = 0; i < NUM_STREAMS; i++) begin
                r_next_id[i] <= LOWEST_ID;
                r_done_id[i] <= FIRST_DONE;
            end
        end else begin
            if (w_in_acc) begin
                r_a_valid <= 1'b1;
                r_seq     <= SEQ_RESP;
            end else if (w_a_done) begin
                r_a_valid <= 1'b0;
            end else if (w_a_emit) begin
                r_seq <= r_seq + 4'd1;
            end

            if (w_a_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (w_a_emit && w_next_upd) begin
                r_next_id[w_cnt_s] <= f_bump(w_next_cur);
            end
            if (w_a_emit && w_done_upd) begin
                r_done_id[w_cnt_s] <= w_res.data;
            end
            if (w_a_emit && w_wr_en) begin
                r_vld[w_wr_addr] <= 1'b1;
            end
            r_rd_vld  <= r_vld[w_rd_addr];
            r_fwd_hit <= w_a_emit && w_wr_en && (w_wr_addr == w_rd_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_a <= i_in_word;
        end
        if (w_a_emit) begin
            r_out <= w_res;
        end
        if (w_a_emit && w_next_upd) begin
            r_id <= w_next_cur;
        end
        r_fwd_data <= r_a.write_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

`ifndef SYNTHESIS
    a_seq_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_a_emit && w_res.last) |=> (!r_a_valid || r_seq == SEQ_RESP))
        else $error("front stage kept a finished item");

    a_seq_launch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && r_seq != SEQ_RESP) |-> w_launch)
        else $error("word sequence running outside a launch");

    a_id_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_next_id[0] >= LOWEST_ID) && (r_done_id[0] >= FIRST_DONE))
        else $error("id counter below its floor");
`endif

endmodule
